/* rtl/dapvm_pkg.sv */
`default_nettype none
package dapvm_pkg;

  localparam int unsigned ADC_W  = 12;
  localparam int unsigned OPT_W  = 8;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned EVT_W  = 2;
  localparam int unsigned CIDX_W = 2;

  // scaling constants
  localparam logic [ADC_W-1:0] MV_FULL   = 12'd3300;
  localparam logic [ADC_W-1:0] ADC_FULL  = 12'd4095;
  localparam logic [ADC_W-1:0] HYST_MV   = 12'd100;
  localparam logic [DIG_W-1:0] DIGIT_MAX = 4'd9;

  // config register indexes
  localparam logic [CIDX_W-1:0] CFG_ALARM_LIMIT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MOVE_THRESH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_OPT_COUNT   = 2'd2;

  // reset values of the config registers
  localparam logic [ADC_W-1:0] ALARM_LIMIT_RST = 12'd3000;
  localparam logic [ADC_W-1:0] MOVE_THRESH_RST = 12'd120;
  localparam logic [OPT_W-1:0] OPT_COUNT_RST   = 8'd0;

  // voltage event codes
  localparam logic [EVT_W-1:0] EVT_NONE  = 2'd0;
  localparam logic [EVT_W-1:0] EVT_RAISE = 2'd1;
  localparam logic [EVT_W-1:0] EVT_CLEAR = 2'd2;

  typedef struct packed {
    logic [ADC_W-1:0] filtered;
    logic [DIG_W-1:0] digit;
    logic [OPT_W-1:0] option;
    logic             moved;
  } pot_res_t;

  typedef struct packed {
    logic [ADC_W-1:0] mv;
    logic [EVT_W-1:0] event_code;
    logic             alarm;
  } mon_res_t;

endpackage
`default_nettype wire

/* rtl/dapvm_pot.sv */
`default_nettype none
module dapvm_pot #(
  parameter int unsigned FILTER_SHIFT = 2
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                en,
  input  wire                                pot_item,
  input  wire        [dapvm_pkg::ADC_W-1:0]  sample,
  input  wire        [dapvm_pkg::ADC_W-1:0]  move_threshold,
  input  wire        [dapvm_pkg::OPT_W-1:0]  option_count,
  output dapvm_pkg::pot_res_t                res
);
  import dapvm_pkg::*;

  logic [ADC_W-1:0]       pot_filtered;
  logic [ADC_W-1:0]       pot_reference;
  logic signed [ADC_W:0]  diff;
  logic signed [ADC_W:0]  step;
  logic signed [ADC_W:0]  sum;
  logic [ADC_W-1:0]       filt_next;
  logic [ADC_W-1:0]       delta;
  logic                   moved;
  logic [ADC_W+3:0]       times10;
  logic [DIG_W-1:0]       digit_raw;
  logic [ADC_W+OPT_W-1:0] opt_prod;
  logic [OPT_W-1:0]       opt_raw;
  logic [OPT_W-1:0]       opt_val;

  // y += (x - y) >>> shift, floor rounding
  assign diff = $signed({1'b0, sample}) - $signed({1'b0, pot_filtered});
  assign step = diff >>> FILTER_SHIFT;
  assign sum  = $signed({1'b0, pot_filtered}) + step;
  assign filt_next = pot_item ? sum[ADC_W-1:0] : pot_filtered;

  assign delta = (filt_next >= pot_reference) ? filt_next - pot_reference
                                              : pot_reference - filt_next;
  assign moved = pot_item && (delta > move_threshold);

  // digit = f*10 >> 12
  assign times10   = {1'b0, filt_next, 3'b000} + {3'b000, filt_next, 1'b0};
  assign digit_raw = times10[ADC_W+3:ADC_W];

  assign opt_prod = {{OPT_W{1'b0}}, filt_next} * {{ADC_W{1'b0}}, option_count};
  assign opt_raw  = opt_prod[ADC_W+OPT_W-1:ADC_W];

  always_comb begin
    if (option_count == '0) begin
      opt_val = '0;
    end else if (opt_raw >= option_count) begin
      opt_val = option_count - 1'b1;
    end else begin
      opt_val = opt_raw;
    end
  end

  assign res.filtered = filt_next;
  assign res.digit    = (digit_raw > DIGIT_MAX) ? DIGIT_MAX : digit_raw;
  assign res.option   = opt_val;
  assign res.moved    = moved;

  always_ff @(posedge clk) begin
    if (rst) begin
      pot_filtered  <= '0;
      pot_reference <= '0;
    end else if (en && pot_item) begin
      pot_filtered <= filt_next;
      if (moved) begin
        pot_reference <= filt_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/dapvm_mon.sv */
`default_nettype none
module dapvm_mon (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                en,
  input  wire                                mon_item,
  input  wire        [dapvm_pkg::ADC_W-1:0]  sample,
  input  wire        [dapvm_pkg::ADC_W-1:0]  alarm_limit_mv,
  output dapvm_pkg::mon_res_t                res
);
  import dapvm_pkg::*;

  logic [ADC_W-1:0]   monitor_mv;
  logic               alarm_active;
  logic [2*ADC_W-1:0] prod;
  logic [ADC_W-1:0]   q0;
  logic [ADC_W:0]     rem;
  logic [ADC_W-1:0]   mv_conv;
  logic [ADC_W-1:0]   mv_next;
  logic [ADC_W-1:0]   clear_at;
  logic               alarm_next;
  logic [EVT_W-1:0]   evt;

  // p / 4095: q0 = p >> 12, remainder p - 4095*q0 = p[11:0] + q0 < 2*4095
  assign prod    = {{ADC_W{1'b0}}, sample} * {{ADC_W{1'b0}}, MV_FULL};
  assign q0      = prod[2*ADC_W-1:ADC_W];
  assign rem     = {1'b0, prod[ADC_W-1:0]} + {1'b0, q0};
  assign mv_conv = (rem >= {1'b0, ADC_FULL}) ? q0 + 1'b1 : q0;
  assign mv_next = mon_item ? mv_conv : monitor_mv;

  assign clear_at = (alarm_limit_mv >= HYST_MV) ? alarm_limit_mv - HYST_MV : '0;

  always_comb begin
    alarm_next = alarm_active;
    evt        = EVT_NONE;
    if (mon_item) begin
      if (!alarm_active) begin
        if (mv_conv > alarm_limit_mv) begin
          alarm_next = 1'b1;
          evt        = EVT_RAISE;
        end
      end else if (mv_conv < clear_at) begin
        alarm_next = 1'b0;
        evt        = EVT_CLEAR;
      end
    end
  end

  assign res.mv         = mv_next;
  assign res.event_code = evt;
  assign res.alarm      = alarm_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_mv   <= '0;
      alarm_active <= 1'b0;
    end else if (en && mon_item) begin
      monitor_mv   <= mv_next;
      alarm_active <= alarm_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/dual_adc_pot_and_voltage_monitor_unit.sv */
`default_nettype none
// Dual-channel ADC post-processor. Each input transaction is one finished
// 12-bit conversion; conversions alternate pot, monitor, pot, ... starting
// with the pot after reset, tracked by an internal toggle. Pot samples feed
// an exponential filter (y += (x-y) >>> FILTER_SHIFT), a movement detector
// against a stored reference, and a mapping to a digit 0..9 and a menu
// option below option_count. Monitor samples are scaled to millivolts
// (x*3300/4095) and drive an over-voltage alarm with a 100 mV hysteresis
// band. Every input gives exactly one output transaction carrying the full
// current state of both channels. Throughput is one transaction per clock
// while out_ready does not stall the output; the path is the input register,
// then the processing stage that writes the filter/alarm state and the
// output register. A new input is taken while a result waits on out_ready
// as long as the input register is free. Config registers (cfg_index 0 alarm
// limit, 1 move threshold, 2 option count) are written with cfg_we and should
// change only while the block holds no transaction.
module dual_adc_pot_and_voltage_monitor_unit #(
  parameter int unsigned FILTER_SHIFT = 2
) (
  input  wire                                clk,
  input  wire                                rst,
  // input channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire        [dapvm_pkg::ADC_W-1:0]  sample,
  // output channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               channel_done,
  output logic       [dapvm_pkg::ADC_W-1:0]  filtered_pot,
  output logic       [dapvm_pkg::DIG_W-1:0]  digit,
  output logic       [dapvm_pkg::OPT_W-1:0]  option,
  output logic       [dapvm_pkg::ADC_W-1:0]  millivolts,
  output logic                               pot_moved,
  output logic       [dapvm_pkg::EVT_W-1:0]  voltage_event,
  output logic                               over_voltage,
  // config write port
  input  wire                                cfg_we,
  input  wire        [dapvm_pkg::CIDX_W-1:0] cfg_index,
  input  wire        [dapvm_pkg::ADC_W-1:0]  cfg_data
);
  import dapvm_pkg::*;

  logic [ADC_W-1:0] alarm_limit_mv;
  logic [ADC_W-1:0] move_threshold;
  logic [OPT_W-1:0] option_count;

  // input register
  logic             s1_valid;
  logic [ADC_W-1:0] s1_sample;
  // channel toggle: 0 pot expected, 1 monitor expected
  logic             expect_monitor;
  logic             advance;

  pot_res_t pot_res;
  mon_res_t mon_res;

  // processing stage fires when the output register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_limit_mv <= ALARM_LIMIT_RST;
      move_threshold <= MOVE_THRESH_RST;
      option_count   <= OPT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALARM_LIMIT: alarm_limit_mv <= cfg_data;
        CFG_MOVE_THRESH: move_threshold <= cfg_data;
        CFG_OPT_COUNT:   option_count   <= cfg_data[OPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample;
    end
  end

  dapvm_pot #(
    .FILTER_SHIFT (FILTER_SHIFT)
  ) u_pot (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .pot_item       (!expect_monitor),
    .sample         (s1_sample),
    .move_threshold (move_threshold),
    .option_count   (option_count),
    .res            (pot_res)
  );

  dapvm_mon u_mon (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .mon_item       (expect_monitor),
    .sample         (s1_sample),
    .alarm_limit_mv (alarm_limit_mv),
    .res            (mon_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_monitor <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        expect_monitor <= !expect_monitor;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      channel_done  <= expect_monitor;
      filtered_pot  <= pot_res.filtered;
      digit         <= pot_res.digit;
      option        <= pot_res.option;
      pot_moved     <= pot_res.moved;
      millivolts    <= mon_res.mv;
      voltage_event <= mon_res.event_code;
      over_voltage  <= mon_res.alarm;
    end
  end

endmodule
`default_nettype wire

/* rtl/dapvm_checker.sv */
`default_nettype none
module dapvm_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire                               channel_done,
  input wire                               pot_moved,
  input wire       [dapvm_pkg::EVT_W-1:0]  voltage_event,
  input wire                               over_voltage,
  input wire       [dapvm_pkg::ADC_W-1:0]  millivolts
);
  import dapvm_pkg::*;

  logic last_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ch <= 1'b1;
    end else if (out_valid && out_ready) begin
      last_ch <= channel_done;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_done)
      && $stable(millivolts))
    else $error("stalled result changed");

  // channels alternate, pot first
  a_alt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> channel_done != last_ch)
    else $error("channel order broken");

  // each channel only reports its own events
  a_own: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (channel_done ? !pot_moved : voltage_event == EVT_NONE))
    else $error("event on wrong channel");

  // event code agrees with alarm state
  a_evt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (voltage_event != EVT_RAISE || over_voltage)
      && (voltage_event != EVT_CLEAR || !over_voltage))
    else $error("event disagrees with alarm");

endmodule

bind dual_adc_pot_and_voltage_monitor_unit dapvm_checker u_dapvm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .channel_done  (channel_done),
  .pot_moved     (pot_moved),
  .voltage_event (voltage_event),
  .over_voltage  (over_voltage),
  .millivolts    (millivolts)
);
`default_nettype wire

/* bench/testbench.sv */
module testbench;
  import dapvm_pkg::*;

  localparam int unsigned FILT_SHIFT  = 2;
  localparam int          PHASE_ITEMS = 210;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          N_DIRECTED  = 25;

  // One output transaction, field order matches the output ports.
  typedef struct packed {
    logic             ch;
    logic [ADC_W-1:0] filt;
    logic [DIG_W-1:0] dig;
    logic [OPT_W-1:0] opt;
    logic [ADC_W-1:0] mv;
    logic             moved;
    logic [EVT_W-1:0] evt;
    logic             ov;
  } reading_t;

  // Directed row: sample, plus an optional hand-written expectation.
  typedef struct packed {
    logic [ADC_W-1:0] smp;
    logic             typed;
    reading_t         want;
  } stim_row_t;

  typedef struct {
    int lim;
    int thr;
    int cnt;
    bit busy;
  } phase_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ADC_W-1:0]  sample = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              channel_done;
  logic [ADC_W-1:0]  filtered_pot;
  logic [DIG_W-1:0]  digit;
  logic [OPT_W-1:0]  option;
  logic [ADC_W-1:0]  millivolts;
  logic              pot_moved;
  logic [EVT_W-1:0]  voltage_event;
  logic              over_voltage;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_ALARM_LIMIT;
  logic [ADC_W-1:0]  cfg_data = '0;

  // Travels with the sample so the scoreboard sees it at the accepting edge.
  logic              row_typed = 1'b0;
  reading_t          row_want = '0;

  dual_adc_pot_and_voltage_monitor_unit #(
    .FILTER_SHIFT(FILT_SHIFT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .channel_done(channel_done),
    .filtered_pot(filtered_pot),
    .digit(digit),
    .option(option),
    .millivolts(millivolts),
    .pot_moved(pot_moved),
    .voltage_event(voltage_event),
    .over_voltage(over_voltage),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the block: register copies and channel state.
  // ---------------------------------------------------------------------
  logic [ADC_W-1:0] lim_mv   = ALARM_LIMIT_RST;
  logic [ADC_W-1:0] move_thr = MOVE_THRESH_RST;
  logic [OPT_W-1:0] opt_cnt  = OPT_COUNT_RST;

  logic             next_is_monitor = 1'b0;  // pot comes first after reset
  logic [ADC_W-1:0] pot_avg    = '0;         // filtered pot
  logic [ADC_W-1:0] pot_anchor = '0;         // movement reference
  logic [ADC_W-1:0] mon_mv     = '0;
  logic             alarm_on   = 1'b0;

  reading_t readings_due[$];   // expected output transactions, oldest first
  int       mismatches  = 0;
  int       cycle_count = 0;

  // stimulus-side state
  bit send_monitor = 1'b0;     // channel of the next transaction we drive
  bit no_idle      = 1'b0;     // phase with no gaps and no stalls
  int knob         = 2048;     // where the pot "sits" for jittered samples

  // Advance the shadow by one conversion and return what the block reports.
  function automatic reading_t process_conversion(input logic [ADC_W-1:0] x);
    reading_t    r;
    int unsigned xv, y, ref_v, span, scaled, lim, clear_at, d, o;
    r     = '0;
    r.evt = EVT_NONE;
    r.ch  = next_is_monitor;
    xv    = x;
    if (!next_is_monitor) begin
      y = pot_avg;
      // floor of (x-y)/2^k: rounds toward the lower value in both directions
      if (xv >= y) y = y + ((xv - y) >> FILT_SHIFT);
      else y = y - ((y - xv + (1 << FILT_SHIFT) - 1) >> FILT_SHIFT);
      pot_avg = y[ADC_W-1:0];
      ref_v   = pot_anchor;
      span    = (y >= ref_v) ? y - ref_v : ref_v - y;
      if (span > move_thr) begin
        pot_anchor = pot_avg;
        r.moved    = 1'b1;
      end
    end else begin
      scaled   = xv * MV_FULL / ADC_FULL;
      mon_mv   = scaled[ADC_W-1:0];
      lim      = lim_mv;
      // clear point saturates at zero for limits under the hysteresis band
      clear_at = (lim >= HYST_MV) ? lim - HYST_MV : 0;
      if (!alarm_on) begin
        if (mon_mv > lim) begin
          alarm_on = 1'b1;
          r.evt    = EVT_RAISE;
        end
      end else if (mon_mv < clear_at) begin
        alarm_on = 1'b0;
        r.evt    = EVT_CLEAR;
      end
    end
    next_is_monitor = !next_is_monitor;

    d = pot_avg * 10 / 4096;
    if (d > DIGIT_MAX) d = DIGIT_MAX;
    if (opt_cnt == 0) begin
      o = 0;
    end else begin
      o = pot_avg * opt_cnt / 4096;
      if (o >= opt_cnt) o = opt_cnt - 1;
    end
    r.filt = pot_avg;
    r.dig  = d[DIG_W-1:0];
    r.opt  = o[OPT_W-1:0];
    r.mv   = mon_mv;
    r.ov   = alarm_on;
    return r;
  endfunction

  task automatic note_error(input string msg);
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard: predict on input transaction, compare on output one.
  // Push before pop so ordering holds even if an output came out in the same cycle as its input.
  // ---------------------------------------------------------------------
  reading_t pred, got, want;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred = process_conversion(sample);
        readings_due.push_back(row_typed ? row_want : pred);
      end
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          note_error("output transaction with nothing pending");
        end else begin
          want = readings_due.pop_front();
          got  = {channel_done, filtered_pot, digit, option, millivolts,
                  pot_moved, voltage_event, over_voltage};
          if (got.ch !== want.ch)
            note_error($sformatf("channel_done %0d, want %0d", got.ch, want.ch));
          if (got.filt !== want.filt)
            note_error($sformatf("filtered_pot %0d, want %0d", got.filt, want.filt));
          if (got.dig !== want.dig)
            note_error($sformatf("digit %0d, want %0d", got.dig, want.dig));
          if (got.opt !== want.opt)
            note_error($sformatf("option %0d, want %0d", got.opt, want.opt));
          if (got.mv !== want.mv)
            note_error($sformatf("millivolts %0d, want %0d", got.mv, want.mv));
          if (got.moved !== want.moved)
            note_error($sformatf("pot_moved %0d, want %0d", got.moved, want.moved));
          if (got.evt !== want.evt)
            note_error($sformatf("voltage_event %0d, want %0d", got.evt, want.evt));
          if (got.ov !== want.ov)
            note_error($sformatf("over_voltage %0d, want %0d", got.ov, want.ov));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Output side backpressure: runs of ready and stalls, mostly short.
  // ---------------------------------------------------------------------
  initial begin
    int   hold;
    logic level;
    hold  = 0;
    level = 1'b1;
    forever begin
      @(posedge clk);
      if (no_idle) begin
        out_ready <= 1'b1;
        hold = 0;
      end else begin
        if (hold == 0) begin
          level = ($urandom_range(0, 99) < 65);
          if (level) hold = $urandom_range(1, 16);
          else if ($urandom_range(0, 9) == 0) hold = $urandom_range(8, 40);
          else hold = $urandom_range(1, 3);
        end else begin
          hold--;
        end
        out_ready <= level;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Random sample for the channel that is due next. Monitor samples cluster
  // around the raise and clear points; pot samples mostly jitter around a
  // slowly wandering knob so the movement check lands on both sides.
  function automatic logic [ADC_W-1:0] pick_sample();
    int r, s, t, j, lim;
    r = $urandom_range(0, 99);
    if (send_monitor) begin
      lim = lim_mv;
      if (r < 70) begin
        t = (r < 35) ? lim : ((lim >= HYST_MV) ? lim - HYST_MV : 0);
        s = (t * ADC_FULL + 1650) / MV_FULL + int'($urandom_range(0, 8)) - 4;
      end else if (r < 90) begin
        s = $urandom_range(0, 4095);
      end else begin
        s = $urandom_range(0, 1) ? 4095 : 0;
      end
    end else begin
      if ($urandom_range(0, 9) == 0) knob = $urandom_range(0, 4095);
      j = (move_thr < 256) ? move_thr + 4 : 64;
      if (r < 60) s = knob + int'($urandom_range(0, 2 * j)) - j;
      else if (r < 85) s = $urandom_range(0, 4095);
      else s = $urandom_range(0, 1) ? 4095 : 0;
    end
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return s[ADC_W-1:0];
  endfunction

  // Drive one transaction and hold it until accepted; valid stays high
  // into the next transaction when no gap follows.
  task automatic send_conversion(input logic [ADC_W-1:0] v, input logic typed,
                                 input reading_t w);
    int g;
    in_valid  <= 1'b1;
    sample    <= v;
    row_typed <= typed;
    row_want  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    send_monitor = !send_monitor;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Let every pending transaction come out, then let the clock run on idle.
  // Wait on the clock first so the last accepted transaction is already queued.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the block empty. One write per edge, enable held.
  task automatic apply_settings(input int lim, input int thr, input int cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALARM_LIMIT;
    cfg_data  <= lim[ADC_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_MOVE_THRESH;
    cfg_data  <= thr[ADC_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_OPT_COUNT;
    cfg_data  <= {{(ADC_W-OPT_W){1'b0}}, cnt[OPT_W-1:0]};
    @(posedge clk);
    cfg_we   <= 1'b0;
    lim_mv   = lim[ADC_W-1:0];
    move_thr = thr[ADC_W-1:0];
    opt_cnt  = cnt[OPT_W-1:0];
  endtask

  // Directed rows, reset settings (limit 3000, threshold 120, no options).
  // Rows alternate pot / monitor. Only the opening rows carry hand values.
  stim_row_t dir_rows [N_DIRECTED] = '{
    // after reset: zero in, everything zero out
    '{12'd0,    1'b1, '{1'b0, 12'd0, 4'd0, 8'd0, 12'd0, 1'b0, EVT_NONE, 1'b0}},
    '{12'd0,    1'b1, '{1'b1, 12'd0, 4'd0, 8'd0, 12'd0, 1'b0, EVT_NONE, 1'b0}},
    // full scale pot: quarter step, moved; full scale monitor raises alarm
    '{12'd4095, 1'b1, '{1'b0, 12'd1023, 4'd2, 8'd0, 12'd0, 1'b1, EVT_NONE, 1'b0}},
    '{12'd4095, 1'b1, '{1'b1, 12'd1023, 4'd2, 8'd0, 12'd3300, 1'b0, EVT_RAISE, 1'b1}},
    '{12'd4095, 1'b0, '0},
    '{12'd4095, 1'b0, '0},   // alarm held
    '{12'd4095, 1'b0, '0},
    '{12'd0,    1'b0, '0},   // clears
    '{12'd4095, 1'b0, '0},
    '{12'd3723, 1'b0, '0},   // exactly 3000 mV: no raise
    '{12'd4095, 1'b0, '0},
    '{12'd3724, 1'b0, '0},   // 3001 mV: raise
    '{12'd4095, 1'b0, '0},
    '{12'd3599, 1'b0, '0},   // 2900 mV: still on
    '{12'd4095, 1'b0, '0},
    '{12'd3598, 1'b0, '0},   // 2899 mV: clear
    '{12'd0,    1'b0, '0},   // filter falling, rounds down
    '{12'd1,    1'b0, '0},
    '{12'd2662, 1'b0, '0},   // one above filter: no change
    '{12'd2048, 1'b0, '0},
    '{12'd2660, 1'b0, '0},   // one below filter: steps down by one
    '{12'd4094, 1'b0, '0},
    '{12'd3200, 1'b0, '0},   // just past threshold against reference
    '{12'd2048, 1'b0, '0},
    '{12'd2796, 1'b0, '0}
  };

  phase_t phases [8];

  initial begin
    // settings per phase; limit under 100 means a raised alarm sticks
    phases[0] = '{3300, 0,    1,   1'b0};
    phases[1] = '{0,    4095, 255, 1'b0};
    phases[2] = '{50,   60,   10,  1'b1};
    phases[3] = '{4095, 120,  0,   1'b0};
    phases[4] = '{100,  30,   7,   1'b0};
    phases[5] = '{2000, 200,  255, 1'b0};
    phases[6] = '{int'($urandom_range(0, 4095)), int'($urandom_range(0, 300)),
                  int'($urandom_range(0, 255)), 1'b1};
    phases[7] = '{int'($urandom_range(100, 3300)), int'($urandom_range(0, 4095)),
                  int'($urandom_range(0, 255)), 1'b0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_conversion(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);

    foreach (phases[p]) begin
      drain();
      apply_settings(phases[p].lim, phases[p].thr, phases[p].cnt);
      no_idle = phases[p].busy;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_conversion(pick_sample(), 1'b0, '0);
    end
    no_idle = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dapvm_pkg.sv
rtl/dapvm_pot.sv
rtl/dapvm_mon.sv
rtl/dual_adc_pot_and_voltage_monitor_unit.sv
rtl/dapvm_checker.sv
bench/testbench.sv
